// ===== design/bnf_pkg.sv =====
`default_nettype none

package bnf_pkg;

    // substitute for a sample flagged as not finite, -90 dB in Q8.8
    localparam logic signed [15:0] NONFINITE_DB = -16'sd23040;

    // register reset values
    localparam logic [15:0]        RISE_ALPHA_RESET = 16'd655;
    localparam logic signed [15:0] INIT_FLOOR_RESET = -16'sd12800;
    localparam logic signed [15:0] BIAS_COMP_RESET  = 16'sd2304;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RISE_ALPHA = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_FLOOR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIAS_COMP  = 2'd2;

    // input opcodes
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // input item
    typedef struct packed {
        logic              opcode;
        logic signed [15:0] energy_db;
        logic              not_finite;
    } sample_t;

    // result item
    typedef struct packed {
        logic [2:0]         band_index;
        logic signed [15:0] band_floor_db;
        logic               frame_done;
        logic signed [15:0] global_floor_db;
    } floor_result_t;

    // window scan control and status
    typedef struct packed {
        logic               start;
        logic signed [15:0] energy_db;
    } scan_req_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] min_db;
    } scan_rsp_t;

    // frame mean control and status
    typedef struct packed {
        logic               start;
        logic signed [15:0] bias_db;
    } mean_req_t;

    typedef struct packed {
        logic               done;
        logic signed [15:0] global_db;
    } mean_rsp_t;

    // main sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MULT,
        ST_UPDATE,
        ST_MEAN,
        ST_HOLD
    } ctl_state_t;

endpackage

`default_nettype wire

// ===== design/bnf_window_scan.sv =====
`default_nettype none

module bnf_window_scan #(
    parameter int NUM_BANDS  = 8,
    parameter int WINDOW_LEN = 64
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  bnf_pkg::scan_req_t                            req,
    input  logic [((NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1)-1:0] band,
    input  logic [$clog2(WINDOW_LEN)-1:0]                 pos,
    input  logic [$clog2(WINDOW_LEN + 1)-1:0]             count,
    output bnf_pkg::scan_rsp_t                            rsp
);

    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int DEPTH  = NUM_BANDS * WINDOW_LEN;
    localparam int ADDR_W = $clog2(DEPTH);

    logic signed [15:0] mem [DEPTH];

    logic [ADDR_W-1:0]  base_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr_reg;
    logic signed [15:0] rdata_reg;
    logic signed [15:0] min_reg;
    logic               reading_reg;
    logic               reading_next;
    logic [FILL_W-1:0]  left_reg;
    logic [FILL_W-1:0]  left_next;
    logic               rdv_reg;
    logic               rdlast_reg;
    logic               done_reg;

    // band row base and write slot
    assign base_addr = ADDR_W'(band) * ADDR_W'(WINDOW_LEN);
    assign wr_addr   = base_addr + ADDR_W'(pos);

    // read sequencing over the filled part of the row
    always_comb
    begin
        reading_next = reading_reg && (left_reg != '0);
        left_next    = left_reg;
        if (req.start)
        begin
            reading_next = 1'b1;
            left_next    = count - FILL_W'(1);
        end
        else if (reading_reg && (left_reg != '0))
        begin
            left_next = left_reg - FILL_W'(1);
        end
    end

    // memory write of the new sample and registered read
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mem[wr_addr] <= req.energy_db;
        end
        if (reading_reg)
        begin
            rdata_reg <= mem[rd_addr_reg];
        end
    end

    // read address and running minimum
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rd_addr_reg <= base_addr;
            min_reg     <= req.energy_db;
        end
        else
        begin
            if (reading_reg)
            begin
                rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
            end
            if (rdv_reg && (rdata_reg < min_reg))
            begin
                min_reg <= rdata_reg;
            end
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reading_reg <= 1'b0;
            left_reg    <= '0;
            rdv_reg     <= 1'b0;
            rdlast_reg  <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            reading_reg <= reading_next;
            left_reg    <= left_next;
            rdv_reg     <= reading_reg;
            rdlast_reg  <= reading_reg && (left_reg == '0);
            done_reg    <= rdv_reg && rdlast_reg;
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.min_db = min_reg;

endmodule

`default_nettype wire

// ===== design/bnf_frame_mean.sv =====
`default_nettype none

module bnf_frame_mean #(
    parameter int NUM_BANDS = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  bnf_pkg::mean_req_t                      req,
    input  logic signed [16 + $clog2(NUM_BANDS)-1:0] sum,
    output bnf_pkg::mean_rsp_t                      rsp
);

    localparam int SUM_W  = 16 + $clog2(NUM_BANDS);
    // reciprocal scale: exact floor quotient for every dividend below 2**SUM_W
    localparam int SHIFT  = SUM_W + $clog2(NUM_BANDS);
    localparam int MUL_W  = SHIFT + 1;
    localparam int PROD_W = SUM_W + MUL_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(NUM_BANDS) - 64'd1) / 64'(NUM_BANDS);
    localparam logic [MUL_W-1:0] RECIP = RECIP_FULL[MUL_W-1:0];
    // offset that makes the sum non-negative, removed again from the quotient
    localparam logic [SUM_W-1:0] OFFSET = SUM_W'(NUM_BANDS * 32768);

    logic [SUM_W-1:0]   dividend_reg;
    logic [15:0]        quot_reg;
    logic               mul_reg;
    logic               add_reg;
    logic               done_reg;
    logic signed [15:0] bias_reg;
    logic signed [15:0] global_reg;

    logic [PROD_W-1:0]  prod;
    logic signed [17:0] g_wide;
    logic signed [15:0] g_sat;

    // quotient by reciprocal multiplication
    assign prod = PROD_W'(dividend_reg) * PROD_W'(RECIP);

    // mean plus bias, saturated
    always_comb
    begin
        g_wide = $signed({2'b00, quot_reg}) - 18'sd32768 + 18'(bias_reg);
        if (g_wide > 18'sd32767)
        begin
            g_sat = 16'sh7FFF;
        end
        else if (g_wide < -18'sd32768)
        begin
            g_sat = 16'sh8000;
        end
        else
        begin
            g_sat = g_wide[15:0];
        end
    end

    // dividend, quotient and result
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dividend_reg <= $unsigned(sum) + OFFSET;
            bias_reg     <= req.bias_db;
        end
        if (mul_reg)
        begin
            quot_reg <= prod[SHIFT +: 16];
        end
        if (add_reg)
        begin
            global_reg <= g_sat;
        end
    end

    // stage status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            add_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            mul_reg  <= req.start;
            add_reg  <= mul_reg;
            done_reg <= add_reg;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.global_db = global_reg;

endmodule

`default_nettype wire

// ===== design/band_noise_floor_min_tracker_unit.sv =====
`default_nettype none

// Per-band noise floor tracker using minimum statistics. Band energies (signed
// Q8.8 dB) come in on the sample channel in band order, one transfer per band;
// each is stored in its band's ring window, the minimum over the filled part of
// the window is found, and the band floor follows it (smoothed upward by
// rise_alpha, immediate downward). Every sample transfer gives one result; the
// last band of a frame also carries the global floor (mean band floor plus
// bias_comp_db, saturated). A restart opcode clears the frame state and loads
// all band floors with init_floor_db and gives no result. The window lives in
// one single-port-read memory scanned one entry per cycle; a sample scans n
// entries, where n = min(frames seen + 1, WINDOW_LEN), and no new sample is
// taken until its result is loaded into the output register; the last band
// of a frame also waits for the mean (reciprocal multiply, then bias and
// saturation). Only window entries written since the last restart are ever
// read, so no clearing pass is needed after reset. The configuration port is
// always ready; write it only while the block is idle.
module band_noise_floor_min_tracker_unit #(
    parameter int NUM_BANDS  = 8,
    parameter int WINDOW_LEN = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  bnf_pkg::sample_t                    sample_data,
    output logic                                floor_valid,
    input  logic                                floor_stall,
    output bnf_pkg::floor_result_t              floor_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bnf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [15:0]                         cfg_data
);

    localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int POS_W  = $clog2(WINDOW_LEN);
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = 16 + $clog2(NUM_BANDS);

    bnf_pkg::ctl_state_t state_reg;
    bnf_pkg::ctl_state_t state_next;

    // configuration
    logic [15:0]        rise_alpha_reg;
    logic signed [15:0] init_floor_reg;
    logic signed [15:0] bias_comp_reg;

    // frame state
    logic [BAND_W-1:0]       band_reg;
    logic [POS_W-1:0]        pos_reg;
    logic [FILL_W-1:0]       fill_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [15:0]      floor_reg [NUM_BANDS];

    // per-sample datapath
    logic signed [15:0]      min_reg;
    logic signed [15:0]      fl_reg;
    logic [31:0]             prod_reg;
    logic                    rise_reg;
    bnf_pkg::floor_result_t  res_reg;

    // output register
    logic                    floor_valid_reg;
    bnf_pkg::floor_result_t  floor_data_reg;

    logic                    sample_fire;
    logic                    is_restart;
    logic                    cfg_fire;
    logic                    last_band;
    logic                    out_free;
    logic                    out_load;
    logic [FILL_W-1:0]       scan_count;
    logic signed [16:0]      diff;
    logic signed [16:0]      rise_sum;
    logic signed [15:0]      new_floor;
    logic signed [SUM_W-1:0] sum_new;

    bnf_pkg::scan_req_t      scan_req;
    bnf_pkg::scan_rsp_t      scan_rsp;
    bnf_pkg::mean_req_t      mean_req;
    bnf_pkg::mean_rsp_t      mean_rsp;

    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign sample_fire = sample_valid && !sample_stall;
    assign is_restart  = sample_data.opcode == bnf_pkg::OP_RESTART;
    assign last_band   = band_reg == BAND_W'(NUM_BANDS - 1);
    assign out_free    = !floor_valid_reg || !floor_stall;

    // entries to scan, including the one just written
    assign scan_count = (fill_reg < FILL_W'(WINDOW_LEN)) ? (fill_reg + FILL_W'(1))
                                                          : FILL_W'(WINDOW_LEN);

    // floor update arithmetic
    always_comb
    begin
        diff      = 17'(min_reg) - 17'(fl_reg);
        rise_sum  = 17'(fl_reg) + $signed({1'b0, prod_reg[31:16]});
        new_floor = rise_reg ? rise_sum[15:0] : min_reg;
        sum_new   = sum_reg + SUM_W'(new_floor);
    end

    // window store and minimum scan
    assign scan_req.start     = (state_reg == bnf_pkg::ST_IDLE) && sample_fire && !is_restart;
    assign scan_req.energy_db = sample_data.not_finite ? bnf_pkg::NONFINITE_DB
                                                       : sample_data.energy_db;

    bnf_window_scan #(
        .NUM_BANDS  (NUM_BANDS),
        .WINDOW_LEN (WINDOW_LEN)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (scan_req),
        .band  (band_reg),
        .pos   (pos_reg),
        .count (scan_count),
        .rsp   (scan_rsp)
    );

    // global floor from the frame sum
    assign mean_req.start   = (state_reg == bnf_pkg::ST_UPDATE) && last_band;
    assign mean_req.bias_db = bias_comp_reg;

    bnf_frame_mean #(
        .NUM_BANDS (NUM_BANDS)
    ) u_mean (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mean_req),
        .sum   (sum_new),
        .rsp   (mean_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bnf_pkg::ST_IDLE:
            begin
                if (sample_fire && !is_restart)
                begin
                    state_next = bnf_pkg::ST_SCAN;
                end
            end
            bnf_pkg::ST_SCAN:
            begin
                if (scan_rsp.done)
                begin
                    state_next = bnf_pkg::ST_MULT;
                end
            end
            bnf_pkg::ST_MULT:
            begin
                state_next = bnf_pkg::ST_UPDATE;
            end
            bnf_pkg::ST_UPDATE:
            begin
                state_next = last_band ? bnf_pkg::ST_MEAN : bnf_pkg::ST_HOLD;
            end
            bnf_pkg::ST_MEAN:
            begin
                if (mean_rsp.done)
                begin
                    state_next = bnf_pkg::ST_HOLD;
                end
            end
            bnf_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = bnf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bnf_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        sample_stall = 1'b1;
        out_load     = 1'b0;
        unique case (state_reg)
            bnf_pkg::ST_IDLE:
            begin
                sample_stall = 1'b0;
            end
            bnf_pkg::ST_HOLD:
            begin
                out_load = out_free;
            end
            default:
            begin
                sample_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bnf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rise_alpha_reg <= bnf_pkg::RISE_ALPHA_RESET;
            init_floor_reg <= bnf_pkg::INIT_FLOOR_RESET;
            bias_comp_reg  <= bnf_pkg::BIAS_COMP_RESET;
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index)
                bnf_pkg::CFG_RISE_ALPHA: rise_alpha_reg <= cfg_data;
                bnf_pkg::CFG_INIT_FLOOR: init_floor_reg <= $signed(cfg_data);
                bnf_pkg::CFG_BIAS_COMP:  bias_comp_reg  <= $signed(cfg_data);
                default:                 rise_alpha_reg <= rise_alpha_reg;
            endcase
        end
    end

    // band floors and frame counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg <= '0;
            pos_reg  <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
            for (int i = 0; i < NUM_BANDS; i++)
            begin
                floor_reg[i] <= bnf_pkg::INIT_FLOOR_RESET;
            end
        end
        else if ((state_reg == bnf_pkg::ST_IDLE) && sample_fire && is_restart)
        begin
            band_reg <= '0;
            pos_reg  <= '0;
            fill_reg <= '0;
            sum_reg  <= '0;
            for (int i = 0; i < NUM_BANDS; i++)
            begin
                floor_reg[i] <= init_floor_reg;
            end
        end
        else if (state_reg == bnf_pkg::ST_UPDATE)
        begin
            floor_reg[band_reg] <= new_floor;
            if (last_band)
            begin
                band_reg <= '0;
                sum_reg  <= '0;
                pos_reg  <= (pos_reg == POS_W'(WINDOW_LEN - 1)) ? '0 : (pos_reg + POS_W'(1));
                if (fill_reg < FILL_W'(WINDOW_LEN))
                begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end
            else
            begin
                band_reg <= band_reg + BAND_W'(1);
                sum_reg  <= sum_new;
            end
        end
    end

    // per-sample datapath
    always_ff @(posedge clk)
    begin
        if ((state_reg == bnf_pkg::ST_SCAN) && scan_rsp.done)
        begin
            min_reg <= scan_rsp.min_db;
            fl_reg  <= floor_reg[band_reg];
        end
        if (state_reg == bnf_pkg::ST_MULT)
        begin
            prod_reg <= rise_alpha_reg * diff[15:0];
            rise_reg <= diff > 17'sd0;
        end
        if (state_reg == bnf_pkg::ST_UPDATE)
        begin
            res_reg.band_index      <= 3'(band_reg);
            res_reg.band_floor_db   <= new_floor;
            res_reg.frame_done      <= last_band;
            res_reg.global_floor_db <= '0;
        end
        else if ((state_reg == bnf_pkg::ST_MEAN) && mean_rsp.done)
        begin
            res_reg.global_floor_db <= mean_rsp.global_db;
        end
    end

    // result output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            floor_valid_reg <= 1'b1;
        end
        else if (floor_valid_reg && !floor_stall)
        begin
            floor_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            floor_data_reg <= res_reg;
        end
    end

    assign floor_valid = floor_valid_reg;
    assign floor_data  = floor_data_reg;

endmodule

`default_nettype wire
